// ----- hw/rtl/c8080_pkg.sv -----
// ----------------------------------------------------------------------------
// c8080_pkg: shared types and constants
// Opcode patterns, sequencer states and ALU operation codes.
// ----------------------------------------------------------------------------
package c8080_pkg;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_EXEC  = 2'd2;

	localparam logic [7:0] OP_HLT = 8'h76;
	localparam logic [7:0] OP_LDA = 8'h3A;
	localparam logic [7:0] OP_STA = 8'h32;

	localparam logic [2:0] FLD_MEM = 3'd6;
	localparam logic [2:0] FLD_ACC = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_DECODE,
		ST_OPND1,
		ST_OPND2,
		ST_DATA,
		ST_EXEC,
		ST_MEMWR,
		ST_MEMRD,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		ALU_ADD, ALU_ADC, ALU_SUB, ALU_SBB, ALU_ANA, ALU_XRA, ALU_ORA, ALU_CMP,
		ALU_INR, ALU_DCR, ALU_PASS
	} alu_op_t;

	typedef struct packed {
		logic [7:0] res;
		logic [4:0] flags;
	} alu_out_t;

endpackage

// ----- hw/rtl/c8080_ram.sv -----
// ----------------------------------------------------------------------------
// c8080_ram: generic single port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module c8080_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write or read one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ----- hw/rtl/c8080_alu.sv -----
// ----------------------------------------------------------------------------
// c8080_alu: shared 8-bit arithmetic unit
// Add, subtract, logic, increment and decrement with 8080 flag rules.
// ----------------------------------------------------------------------------
module c8080_alu import c8080_pkg::*; (
	input  alu_op_t    op,
	input  logic [7:0] a,
	input  logic [7:0] v,
	input  logic [4:0] flags_in,
	output alu_out_t   y
);
	logic [8:0] sum;
	logic [4:0] lo;
	logic [7:0] bv;
	logic       cin;
	logic       ac;
	logic       cy;
	logic [7:0] r;

	// one adder serves every arithmetic operation
	always_comb begin
		bv  = v;
		cin = 1'b0;
		case (op)
			ALU_ADC: cin = flags_in[0];
			ALU_SUB, ALU_CMP: begin
				bv  = ~v;
				cin = 1'b1;
			end
			ALU_SBB: begin
				bv  = ~v;
				cin = ~flags_in[0];
			end
			ALU_INR: begin
				bv  = 8'h01;
			end
			ALU_DCR: begin
				bv  = 8'hFF;
			end
			default: ;
		endcase
		sum = {1'b0, a} + {1'b0, bv} + {8'd0, cin};
		lo  = {1'b0, a[3:0]} + {1'b0, bv[3:0]} + {4'd0, cin};
		r   = sum[7:0];
		ac  = lo[4];
		cy  = sum[8];
		case (op)
			ALU_SUB, ALU_SBB, ALU_CMP: cy = ~sum[8];
			ALU_ANA: begin
				r  = a & v;
				ac = a[3] | v[3];
				cy = 1'b0;
			end
			ALU_XRA: begin
				r  = a ^ v;
				ac = 1'b0;
				cy = 1'b0;
			end
			ALU_ORA: begin
				r  = a | v;
				ac = 1'b0;
				cy = 1'b0;
			end
			ALU_INR: begin
				ac = a[3:0] == 4'hF;
				cy = flags_in[0];
			end
			ALU_DCR: begin
				ac = a[3:0] != 4'h0;
				cy = flags_in[0];
			end
			ALU_PASS: begin
				r  = v;
				ac = flags_in[1];
				cy = flags_in[0];
			end
			default: ;
		endcase
		y.res   = r;
		y.flags = {r[7], r == 8'd0, ~^r, ac, cy};
		if (op == ALU_PASS) begin
			y.flags = flags_in;
		end
	end
endmodule

// ----- hw/rtl/cpu8080_subset_step.sv -----
// ----------------------------------------------------------------------------
// cpu8080_subset_step: 8080 subset core with its own byte memory
// Sequencer drives one memory port and one shared ALU per item.
// ----------------------------------------------------------------------------
// Usage: pulse start with mode, address and write_data while busy is low.
// busy rises the next cycle and stays high until the result strobe done,
// which holds all result ports valid for exactly one cycle; the receiver
// cannot stall, so the next start may follow in the cycle after done.
// A memory write passes MEMWR and DONE, a memory read MEMRD, DATA and DONE.
// Execute reads every fetched or data byte through the single RAM port
// with registered read data, one new address per cycle: instructions without
// a memory read (MOV, ALU register ops, NOP, HLT, stores through HL) pass
// FETCH, DECODE, EXEC and DONE; MVI and ALU immediate add OPND1, reads at HL
// add DATA, LXI and STA add OPND1 and OPND2, LDA adds OPND1, OPND2 and DATA.
// Mode three and a halted execute take the memory write path without writing, with cost zero.
// The block takes one transfer at a time: the next transfer follows done.
// Reset clears registers, flags, PC, halt and the T-state total; memory
// contents stay undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
module cpu8080_subset_step import c8080_pkg::*; #(
	parameter int ADDR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	output logic        done,
	output logic [7:0]  read_data,
	output logic [7:0]  acc_value,
	output logic [4:0]  flag_bits,
	output logic [15:0] pair_bc,
	output logic [15:0] pair_de,
	output logic [15:0] pair_hl,
	output logic [15:0] prog_counter,
	output logic        is_halted,
	output logic [3:0]  step_cost,
	output logic [31:0] cycle_total
);
	localparam int DEPTH = 1 << ADDR_BITS;

	state_t      state_q, state_d;
	logic [1:0]  mode_q;
	logic [15:0] addr_q;
	logic [7:0]  wdata_q;
	logic [7:0]  op_q, lo_q;
	logic [7:0]  acc_q;
	logic [7:0]  regs_q [6];
	logic [15:0] pc_q;
	logic [4:0]  flags_q;
	logic        halt_q;
	logic [31:0] total_q;
	logic [3:0]  cost_q;
	logic [7:0]  rd_q;

	logic        ram_we;
	logic [15:0] ram_addr;
	logic [7:0]  ram_wdata, ram_rdata;
	alu_op_t     alu_op;
	logic [7:0]  alu_a, alu_v;
	alu_out_t    alu_y;

	logic [2:0]  dst, src;
	logic        is_mov, is_mvi, is_lxi, is_incdec, is_alu, is_imm;
	logic [15:0] hl;

	assign dst       = op_q[5:3];
	assign src       = op_q[2:0];
	assign hl        = {regs_q[4], regs_q[5]};
	assign is_mov    = op_q[7:6] == 2'b01 && op_q != OP_HLT;
	assign is_mvi    = (op_q & 8'hC7) == 8'h06;
	assign is_lxi    = (op_q & 8'hCF) == 8'h01 && op_q[5:4] != 2'b11;
	assign is_incdec = (op_q & 8'hC6) == 8'h04;
	assign is_imm    = (op_q & 8'hC7) == 8'hC6;
	assign is_alu    = op_q[7:6] == 2'b10 || is_imm;

	c8080_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr[ADDR_BITS-1:0]),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	c8080_alu u_alu (
		.op       (alu_op),
		.a        (alu_a),
		.v        (alu_v),
		.flags_in (flags_q),
		.y        (alu_y)
	);

	function automatic logic [7:0] reg_of(input logic [2:0] f, input logic [7:0] r [6],
			input logic [7:0] acc);
		logic [7:0] x;
		x = acc;
		if (f < FLD_MEM) begin
			x = r[f];
		end
		return x;
	endfunction

	// source operand: memory or immediate byte just read, or a register
	logic [7:0] src_val;
	always_comb begin
		src_val = reg_of(src, regs_q, acc_q);
		if (src == FLD_MEM || is_imm || is_mvi) begin
			src_val = lo_q;
		end
	end

	// next state, memory port and ALU control
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_addr  = pc_q;
		ram_wdata = acc_q;
		alu_a     = acc_q;
		alu_v     = src_val;
		alu_op    = ALU_PASS;
		if (is_alu) begin
			alu_op = alu_op_t'({1'b0, dst});
		end else if (is_incdec) begin
			alu_op = op_q[0] ? ALU_DCR : ALU_INR;
			alu_a  = (dst == FLD_MEM) ? lo_q : reg_of(dst, regs_q, acc_q);
		end
		case (state_q)
			ST_IDLE: begin
				ram_addr = address;
				if (start) begin
					if (mode == MODE_EXEC && !halt_q) begin
						ram_addr = pc_q;
						state_d  = ST_FETCH;
					end else begin
						state_d = (mode == MODE_READ) ? ST_MEMRD : ST_MEMWR;
					end
				end
			end
			ST_MEMWR: begin
				ram_addr  = addr_q;
				ram_wdata = wdata_q;
				ram_we    = mode_q == MODE_WRITE;
				state_d   = ST_DONE;
			end
			ST_MEMRD: begin
				ram_addr = addr_q;
				state_d  = ST_DATA;
			end
			ST_FETCH: state_d = ST_DECODE;
			ST_DECODE: begin
				state_d = ST_EXEC;
				if (is_mvi || is_imm || is_lxi || op_q == OP_LDA || op_q == OP_STA) begin
					state_d = ST_OPND1;
				end else if ((is_mov && src == FLD_MEM) ||
						(is_alu && src == FLD_MEM) || (is_incdec && dst == FLD_MEM)) begin
					ram_addr = hl;
					state_d  = ST_DATA;
				end
			end
			ST_OPND1: begin
				state_d = (is_mvi || is_imm) ? ST_EXEC : ST_OPND2;
			end
			ST_OPND2: begin
				state_d = ST_EXEC;
				if (op_q == OP_LDA) begin
					ram_addr = {ram_rdata, lo_q};
					state_d  = ST_DATA;
				end else if (op_q == OP_STA) begin
					ram_addr = {ram_rdata, lo_q};
					ram_we   = 1'b1;
				end
			end
			ST_DATA: state_d = (mode_q == MODE_READ) ? ST_DONE : ST_EXEC;
			ST_EXEC: begin
				ram_addr  = hl;
				ram_wdata = (is_incdec) ? alu_y.res : src_val;
				ram_we    = dst == FLD_MEM && (is_mov || is_mvi || is_incdec);
				state_d   = ST_DONE;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// T-state cost of the decoded instruction
	logic [3:0] exec_cost;
	always_comb begin
		exec_cost = 4'd4;
		if (is_mov) exec_cost = (dst == FLD_MEM || src == FLD_MEM) ? 4'd7 : 4'd5;
		else if (is_mvi) exec_cost = (dst == FLD_MEM) ? 4'd10 : 4'd7;
		else if (is_lxi) exec_cost = 4'd10;
		else if (op_q == OP_LDA || op_q == OP_STA) exec_cost = 4'd13;
		else if (is_incdec) exec_cost = (dst == FLD_MEM) ? 4'd10 : 4'd5;
		else if (is_alu) exec_cost = (is_imm || src == FLD_MEM) ? 4'd7 : 4'd4;
		else if (op_q == OP_HLT) exec_cost = 4'd7;
	end

	// sequencer and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q   <= '0;
			for (int i = 0; i < 6; i++) regs_q[i] <= '0;
			pc_q    <= '0;
			flags_q <= '0;
			halt_q  <= 1'b0;
			total_q <= '0;
			cost_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						mode_q  <= mode;
						addr_q  <= address;
						wdata_q <= write_data;
						cost_q  <= '0;
						rd_q    <= '0;
						if (mode == MODE_EXEC && !halt_q) begin
							pc_q <= pc_q + 16'd1;
						end
					end
				end
				ST_FETCH: op_q <= ram_rdata;
				ST_DECODE: begin
					if (state_d == ST_OPND1) begin
						pc_q <= pc_q + 16'd1;
					end
				end
				ST_OPND1: begin
					lo_q <= ram_rdata;
					if (state_d == ST_OPND2) begin
						pc_q <= pc_q + 16'd1;
					end
				end
				ST_OPND2: begin
					if (is_lxi) begin
						regs_q[{op_q[5:4], 1'b0}] <= ram_rdata;
						regs_q[{op_q[5:4], 1'b1}] <= lo_q;
					end
				end
				ST_DATA: begin
					lo_q <= ram_rdata;
					if (mode_q == MODE_READ) begin
						rd_q <= ram_rdata;
					end
				end
				ST_EXEC: begin
					if (op_q == OP_LDA) begin
						acc_q <= lo_q;
					end else if (is_mov || is_mvi) begin
						if (dst == FLD_ACC) acc_q <= src_val;
						else if (dst != FLD_MEM) regs_q[dst] <= src_val;
					end else if (is_incdec) begin
						flags_q <= alu_y.flags;
						if (dst == FLD_ACC) acc_q <= alu_y.res;
						else if (dst != FLD_MEM) regs_q[dst] <= alu_y.res;
					end else if (is_alu) begin
						flags_q <= alu_y.flags;
						if (dst != FLD_ACC) acc_q <= alu_y.res;
					end
					if (op_q == OP_HLT) begin
						halt_q <= 1'b1;
					end
					cost_q <= exec_cost;
					total_q <= total_q + {28'd0, exec_cost};
				end
				default: ;
			endcase
		end
	end

	assign busy         = state_q != ST_IDLE;
	assign done         = state_q == ST_DONE;
	assign read_data    = rd_q;
	assign acc_value    = acc_q;
	assign flag_bits    = flags_q;
	assign pair_bc      = {regs_q[0], regs_q[1]};
	assign pair_de      = {regs_q[2], regs_q[3]};
	assign pair_hl      = hl;
	assign prog_counter = pc_q;
	assign is_halted    = halt_q;
	assign step_cost    = cost_q;
	assign cycle_total  = total_q;

	// a result strobe is always raised while busy
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("done without busy");
	// a start while idle makes the block busy
	a_start: assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("start not taken");
	// done lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done longer than one cycle");
	// total only moves by the reported cost
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (cycle_total == $past(cycle_total) + {28'd0, step_cost}))
		else $error("total mismatch");
endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for cpu8080_subset_step
// Drives memory writes, reads and single-instruction executes through the
// start/busy command port and checks every strobed result against an
// internal model of the core. A short directed program comes first, then
// random instruction sequences that load their bytes before executing them.
// The run ends with a halt and a few transfers on the halted core.
// ----------------------------------------------------------------------------
module testbench;
	import c8080_pkg::*;

	localparam logic [1:0] MODE_NONE  = 2'd3;
	localparam logic [7:0] OP_NOP     = 8'h00;
	localparam logic [7:0] OP_MVI_A   = 8'h3E;
	localparam logic [7:0] OP_ADI     = 8'hC6;
	localparam logic [7:0] OP_LXI_H   = 8'h21;
	localparam logic [7:0] OP_LXI_SP  = 8'h31;
	localparam logic [7:0] OP_ADD_M   = 8'h86;
	localparam logic [7:0] OP_CMP_M   = 8'hBE;
	localparam logic [7:0] OP_DCR_M   = 8'h35;
	localparam int         NUM_ITEMS  = 600;
	localparam int         CYCLE_CAP  = 400000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  mode;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic        done;
	logic [7:0]  read_data;
	logic [7:0]  acc_value;
	logic [4:0]  flag_bits;
	logic [15:0] pair_bc;
	logic [15:0] pair_de;
	logic [15:0] pair_hl;
	logic [15:0] prog_counter;
	logic        is_halted;
	logic [3:0]  step_cost;
	logic [31:0] cycle_total;

	cpu8080_subset_step dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .address(address), .write_data(write_data),
		.done(done), .read_data(read_data), .acc_value(acc_value),
		.flag_bits(flag_bits), .pair_bc(pair_bc), .pair_de(pair_de),
		.pair_hl(pair_hl), .prog_counter(prog_counter), .is_halted(is_halted),
		.step_cost(step_cost), .cycle_total(cycle_total)
	);

	typedef struct {
		logic [7:0]  rd;
		logic [7:0]  acc;
		logic [4:0]  flags;
		logic [15:0] bc;
		logic [15:0] de;
		logic [15:0] hl;
		logic [15:0] pc;
		logic        halted;
		logic [3:0]  cost;
		logic [31:0] total;
		int          fixed_rd;
		int          fixed_cost;
		int          fixed_pc;
	} core_state_t;

	typedef struct {
		logic [1:0]  mode;
		logic [15:0] addr;
		logic [7:0]  data;
		int          rd;
		int          cost;
		int          pc;
	} cmd_row_t;

	// model state
	logic [7:0]  m_acc;
	logic [7:0]  m_regs [6];
	logic [15:0] m_pc;
	logic [4:0]  m_flags;
	logic        m_halt;
	logic [31:0] m_total;
	logic [7:0]  m_mem   [65536];
	bit          m_known [65536];
	logic [15:0] known_addrs [$];

	core_state_t pending_results [$];
	int          errors;
	int          cycles;
	int          sent;
	bit          no_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] hl_ptr();
		return {m_regs[4], m_regs[5]};
	endfunction

	function automatic void mem_store(logic [15:0] a, logic [7:0] v);
		m_mem[a] = v;
		if (!m_known[a])
			known_addrs.push_back(a);
		m_known[a] = 1'b1;
	endfunction

	function automatic logic [7:0] next_byte();
		logic [7:0] v;
		v = m_mem[m_pc];
		m_pc = m_pc + 16'd1;
		return v;
	endfunction

	function automatic logic [7:0] get_fld(logic [2:0] idx);
		if (idx == FLD_MEM)
			return m_mem[hl_ptr()];
		if (idx == FLD_ACC)
			return m_acc;
		return m_regs[idx];
	endfunction

	function automatic void put_fld(logic [2:0] idx, logic [7:0] v);
		if (idx == FLD_MEM)
			mem_store(hl_ptr(), v);
		else if (idx == FLD_ACC)
			m_acc = v;
		else
			m_regs[idx] = v;
	endfunction

	// replace sign, zero and parity; keep aux carry and carry
	function automatic void set_szp(logic [7:0] v);
		m_flags = {v[7], v == 8'd0, ~^v, m_flags[1:0]};
	endfunction

	// execute one instruction, return its T-states
	function automatic int run_instr();
		logic [7:0]  op;
		logic [2:0]  dst;
		logic [2:0]  src;
		logic [7:0]  v;
		logic [7:0]  nv;
		logic [7:0]  res;
		logic [15:0] w;
		logic [8:0]  sum;
		logic [4:0]  low;
		logic        c;
		logic        ac;
		logic        cy;
		op  = next_byte();
		dst = op[5:3];
		src = op[2:0];
		if (op[7:6] == 2'b01 && op != OP_HLT) begin
			put_fld(dst, get_fld(src));
			return (dst == FLD_MEM || src == FLD_MEM) ? 7 : 5;
		end
		if (op[7:6] == 2'b00 && src == 3'd6) begin
			put_fld(dst, next_byte());
			return dst == FLD_MEM ? 10 : 7;
		end
		if ((op & 8'hCF) == 8'h01 && op[5:4] != 2'b11) begin
			w[7:0]  = next_byte();
			w[15:8] = next_byte();
			m_regs[op[5:4] * 2]     = w[15:8];
			m_regs[op[5:4] * 2 + 1] = w[7:0];
			return 10;
		end
		if (op == OP_LDA || op == OP_STA) begin
			w[7:0]  = next_byte();
			w[15:8] = next_byte();
			if (op == OP_LDA)
				m_acc = m_mem[w];
			else
				mem_store(w, m_acc);
			return 13;
		end
		if (op[7:6] == 2'b00 && (src == 3'd4 || src == 3'd5)) begin
			v  = get_fld(dst);
			nv = (src == 3'd4) ? v + 8'd1 : v - 8'd1;
			ac = (src == 3'd4) ? (v[3:0] == 4'hF) : (v[3:0] != 4'h0);
			put_fld(dst, nv);
			m_flags[1] = ac;
			set_szp(nv);
			return dst == FLD_MEM ? 10 : 5;
		end
		if (op[7:6] == 2'b10 || (op[7:6] == 2'b11 && src == 3'd6)) begin
			v = (op[7:6] == 2'b11) ? next_byte() : get_fld(src);
			case (dst)
				3'd0, 3'd1: begin
					c   = (dst == 3'd1) ? m_flags[0] : 1'b0;
					sum = {1'b0, m_acc} + {1'b0, v} + c;
					low = {1'b0, m_acc[3:0]} + {1'b0, v[3:0]} + c;
					res = sum[7:0];
					cy  = sum[8];
					ac  = low[4];
				end
				3'd2, 3'd3, 3'd7: begin
					c   = (dst == 3'd3) ? ~m_flags[0] : 1'b1;
					nv  = ~v;
					sum = {1'b0, m_acc} + {1'b0, nv} + c;
					low = {1'b0, m_acc[3:0]} + {1'b0, nv[3:0]} + c;
					res = sum[7:0];
					cy  = ~sum[8];
					ac  = low[4];
				end
				3'd4: begin
					res = m_acc & v;
					cy  = 1'b0;
					ac  = m_acc[3] | v[3];
				end
				3'd5: begin
					res = m_acc ^ v;
					cy  = 1'b0;
					ac  = 1'b0;
				end
				default: begin
					res = m_acc | v;
					cy  = 1'b0;
					ac  = 1'b0;
				end
			endcase
			m_flags[1:0] = {ac, cy};
			set_szp(res);
			if (dst != 3'd7)
				m_acc = res;
			return (op[7:6] == 2'b11 || src == FLD_MEM) ? 7 : 4;
		end
		if (op == OP_HLT) begin
			m_halt = 1'b1;
			return 7;
		end
		return 4;
	endfunction

	// advance the model by one transfer and queue the result it causes
	function automatic void predict_item(logic [1:0] md, logic [15:0] a, logic [7:0] d,
			int fx_rd, int fx_cost, int fx_pc);
		core_state_t r;
		int cost;
		r.rd = 8'd0;
		cost = 0;
		if (md == MODE_WRITE)
			mem_store(a, d);
		else if (md == MODE_READ)
			r.rd = m_mem[a];
		else if (md == MODE_EXEC && !m_halt) begin
			cost = run_instr();
			m_total = m_total + cost;
		end
		r.acc        = m_acc;
		r.flags      = m_flags;
		r.bc         = {m_regs[0], m_regs[1]};
		r.de         = {m_regs[2], m_regs[3]};
		r.hl         = hl_ptr();
		r.pc         = m_pc;
		r.halted     = m_halt;
		r.cost       = cost;
		r.total      = m_total;
		r.fixed_rd   = fx_rd;
		r.fixed_cost = fx_cost;
		r.fixed_pc   = fx_pc;
		pending_results.push_back(r);
	endfunction

	// idle gaps: mostly short, a few long, none during quiet stretches
	function automatic int pick_gap();
		int p;
		if (no_idle)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// present one command and hold it until the transfer
	task automatic send(logic [1:0] md, logic [15:0] a, logic [7:0] d,
			int fx_rd = -1, int fx_cost = -1, int fx_pc = -1);
		int gap;
		start      <= 1'b1;
		mode       <= md;
		address    <= a;
		write_data <= d;
		do
			@(posedge clk);
		while (busy);
		predict_item(md, a, d, fx_rd, fx_cost, fx_pc);
		sent++;
		if (sent % 50 == 0)
			no_idle = ($urandom_range(0, 3) == 0);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// load one instruction with its operands and data, then execute it
	task automatic run_random_instr();
		logic [7:0]  op;
		logic [15:0] tgt;
		logic [7:0]  opnd [3];
		int          len;
		bit          reads_m;
		op = $urandom_range(0, 255);
		if (op == OP_HLT)
			op = OP_NOP;
		opnd[0] = op;
		opnd[1] = $urandom_range(0, 255);
		opnd[2] = $urandom_range(0, 255);
		len = 1;
		if ((op[7:6] == 2'b00 && op[2:0] == 3'd6) || (op[7:6] == 2'b11 && op[2:0] == 3'd6))
			len = 2;
		if (((op & 8'hCF) == 8'h01 && op != OP_LXI_SP) || op == OP_LDA || op == OP_STA)
			len = 3;
		reads_m = (op[7:6] == 2'b01 && op[2:0] == FLD_MEM) ||
			(op[7:6] == 2'b10 && op[2:0] == FLD_MEM) ||
			(op[7:6] == 2'b00 && op[5:3] == FLD_MEM && (op[2:0] == 3'd4 || op[2:0] == 3'd5));
		if (reads_m && !m_known[hl_ptr()])
			send(MODE_WRITE, hl_ptr(), $urandom_range(0, 255));
		if (op == OP_LDA) begin
			tgt = {opnd[2], opnd[1]};
			if (!m_known[tgt])
				send(MODE_WRITE, tgt, $urandom_range(0, 255));
		end
		for (int i = 0; i < len; i++)
			send(MODE_WRITE, m_pc + i, opnd[i]);
		send(MODE_EXEC, $urandom_range(0, 65535), $urandom_range(0, 255));
	endtask

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	// compare each strobed result with the oldest expectation
	always @(posedge clk) begin
		core_state_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result strobe with no transfer outstanding");
				errors++;
			end else begin
				e = pending_results.pop_front();
				check_field("read_data", e.rd, read_data);
				check_field("acc_value", e.acc, acc_value);
				check_field("flag_bits", e.flags, flag_bits);
				check_field("pair_bc", e.bc, pair_bc);
				check_field("pair_de", e.de, pair_de);
				check_field("pair_hl", e.hl, pair_hl);
				check_field("prog_counter", e.pc, prog_counter);
				check_field("is_halted", e.halted, is_halted);
				check_field("step_cost", e.cost, step_cost);
				check_field("cycle_total", e.total, cycle_total);
				if (e.fixed_rd >= 0)
					check_field("read_data", e.fixed_rd, read_data);
				if (e.fixed_cost >= 0)
					check_field("step_cost", e.fixed_cost, step_cost);
				if (e.fixed_pc >= 0)
					check_field("prog_counter", e.fixed_pc, prog_counter);
			end
		end
	end

	// drop the run if it hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("simulation failed");
			$finish;
		end
	end

	cmd_row_t directed [25] = '{
		'{MODE_NONE,  16'h0000, 8'h00,     -1,  0,  0},
		'{MODE_WRITE, 16'h0000, OP_MVI_A,  -1, -1, -1},
		'{MODE_WRITE, 16'h0001, 8'hFF,     -1, -1, -1},
		'{MODE_WRITE, 16'hFFFF, 8'h80,     -1, -1, -1},
		'{MODE_READ,  16'hFFFF, 8'h00,   8'h80,  0,  0},
		'{MODE_EXEC,  16'h0000, 8'h00,     -1,  7,  2},
		'{MODE_WRITE, 16'h0002, OP_ADI,    -1, -1, -1},
		'{MODE_WRITE, 16'h0003, 8'h01,     -1, -1, -1},
		'{MODE_EXEC,  16'hFFFF, 8'hFF,     -1,  7,  4},
		'{MODE_WRITE, 16'h0004, OP_LXI_H,  -1, -1, -1},
		'{MODE_WRITE, 16'h0005, 8'hFF,     -1, -1, -1},
		'{MODE_WRITE, 16'h0006, 8'hFF,     -1, -1, -1},
		'{MODE_EXEC,  16'h0000, 8'h00,     -1, 10,  7},
		'{MODE_WRITE, 16'h0007, OP_ADD_M,  -1, -1, -1},
		'{MODE_EXEC,  16'h0000, 8'h00,     -1,  7,  8},
		'{MODE_WRITE, 16'h0008, OP_LXI_SP, -1, -1, -1},
		'{MODE_EXEC,  16'h0000, 8'h00,     -1,  4,  9},
		'{MODE_WRITE, 16'h0009, OP_CMP_M,  -1, -1, -1},
		'{MODE_EXEC,  16'h0000, 8'h00,     -1,  7, 10},
		'{MODE_WRITE, 16'h000A, OP_DCR_M,  -1, -1, -1},
		'{MODE_EXEC,  16'h0000, 8'h00,     -1, 10, 11},
		'{MODE_WRITE, 16'h000B, OP_LDA,    -1, -1, -1},
		'{MODE_WRITE, 16'h000C, 8'hFF,     -1, -1, -1},
		'{MODE_WRITE, 16'h000D, 8'hFF,     -1, -1, -1},
		'{MODE_EXEC,  16'h0000, 8'h00,     -1, 13, 14}
	};

	initial begin
		int p;
		int wait_cnt;
		logic [15:0] a;
		errors     = 0;
		cycles     = 0;
		sent       = 0;
		no_idle    = 1'b0;
		m_acc      = 8'd0;
		m_pc       = 16'd0;
		m_flags    = 5'd0;
		m_halt     = 1'b0;
		m_total    = 32'd0;
		for (int i = 0; i < 6; i++)
			m_regs[i] = 8'd0;
		arst_n     = 1'b0;
		start      = 1'b0;
		mode       = MODE_WRITE;
		address    = 16'd0;
		write_data = 8'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed program
		foreach (directed[i])
			send(directed[i].mode, directed[i].addr, directed[i].data,
				directed[i].rd, directed[i].cost, directed[i].pc);

		// random sequences, with noise transfers mixed in
		while (sent < NUM_ITEMS) begin
			p = $urandom_range(0, 99);
			if (p < 78)
				run_random_instr();
			else if (p < 86)
				send(MODE_WRITE, $urandom_range(0, 65535), $urandom_range(0, 255));
			else if (p < 95) begin
				a = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
				send(MODE_READ, a, $urandom_range(0, 255));
			end else
				send(MODE_NONE, $urandom_range(0, 65535), $urandom_range(0, 255));
		end

		// halt, then show the halted core ignores executes
		send(MODE_WRITE, m_pc, OP_HLT);
		send(MODE_EXEC, 16'h0000, 8'h00, -1, 7, -1);
		send(MODE_EXEC, 16'hFFFF, 8'hFF, -1, 0, -1);
		send(MODE_WRITE, 16'h00FF, 8'h5A);
		send(MODE_READ, 16'h00FF, 8'h00, 8'h5A, 0, -1);
		send(MODE_NONE, 16'h0000, 8'h00, -1, 0, -1);
		start <= 1'b0;

		wait_cnt = 0;
		while (pending_results.size() != 0 && wait_cnt < 1000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
